[src/bship_pkg.sv]
// ============================================================================
// Burning Ship escape-time package
// Shared widths, configuration codes, record types and fixed-point helpers.
// ============================================================================
package bship_pkg;

    // Fixed-point format: signed, FRAC_BITS fraction bits, four integer bits.
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 11;
    localparam int VAL_BITS   = FRAC_BITS + 4;
    localparam int MAG_BITS   = FRAC_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS - FRAC_BITS;
    localparam int WIDE_BITS  = VAL_BITS + 2;

    // Register and field widths.
    localparam int SIZE_BITS     = 12;
    localparam int OFS_BITS      = 32;
    localparam int STEP_BITS     = 31;
    localparam int CNT_BITS      = 10;
    localparam int COLOUR_BITS   = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Pixel to point mapping widths.
    localparam int DIFF_BITS = ((COORD_BITS > SIZE_BITS - 1) ? COORD_BITS : SIZE_BITS - 1) + 1;
    localparam int PROD_BITS = DIFF_BITS + STEP_BITS + 1;
    localparam int MAP_MAX   = (PROD_BITS > OFS_BITS) ?
                               ((PROD_BITS > VAL_BITS) ? PROD_BITS : VAL_BITS) :
                               ((OFS_BITS > VAL_BITS) ? OFS_BITS : VAL_BITS);
    localparam int MAP_BITS  = MAP_MAX + 1;

    // Iteration ring.
    localparam int RING_DEPTH = 4;
    localparam int TAG_BITS   = $clog2(RING_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_OFF_X,
        CFG_OFF_Y,
        CFG_STEP_X,
        CFG_STEP_Y,
        CFG_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        logic        [SIZE_BITS-1:0] width;
        logic        [SIZE_BITS-1:0] height;
        logic signed [OFS_BITS-1:0]  off_x;
        logic signed [OFS_BITS-1:0]  off_y;
        logic        [STEP_BITS-1:0] step_x;
        logic        [STEP_BITS-1:0] step_y;
    } geo_t;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] cr;
        logic signed [VAL_BITS-1:0] ci;
    } point_t;

    typedef struct packed {
        logic                       valid;
        logic                       done;
        logic                       bounded;
        logic [TAG_BITS-1:0]        tag;
        logic [CNT_BITS-1:0]        n;
        logic signed [VAL_BITS-1:0] cr;
        logic signed [VAL_BITS-1:0] ci;
    } meta_t;

    typedef struct packed {
        logic                valid;
        logic [CNT_BITS-1:0] count;
        logic                bounded;
    } result_t;

    // Saturate the wide mapping sum to the value range.
    function automatic logic signed [VAL_BITS-1:0] sat_map(
        input logic signed [MAP_BITS-1:0] v
    );
        logic [MAP_BITS-VAL_BITS:0] top;
        logic signed [VAL_BITS-1:0] r;
        top = v[MAP_BITS-1:VAL_BITS-1];
        if ((&top) || (~|top))
            r = v[VAL_BITS-1:0];
        else if (v[MAP_BITS-1])
            r = {1'b1, {(VAL_BITS-1){1'b0}}};
        else
            r = {1'b0, {(VAL_BITS-1){1'b1}}};
        return r;
    endfunction

    // Saturate an iteration sum to the value range.
    function automatic logic signed [VAL_BITS-1:0] sat_wide(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic [WIDE_BITS-VAL_BITS:0] top;
        logic signed [VAL_BITS-1:0] r;
        top = v[WIDE_BITS-1:VAL_BITS-1];
        if ((&top) || (~|top))
            r = v[VAL_BITS-1:0];
        else if (v[WIDE_BITS-1])
            r = {1'b1, {(VAL_BITS-1){1'b0}}};
        else
            r = {1'b0, {(VAL_BITS-1){1'b1}}};
        return r;
    endfunction

    // Absolute value; the most negative value maps to the most positive.
    function automatic logic signed [VAL_BITS-1:0] abs_sat(
        input logic signed [VAL_BITS-1:0] v
    );
        logic [VAL_BITS-1:0] neg;
        logic signed [VAL_BITS-1:0] r;
        neg = -v;
        if (!v[VAL_BITS-1])
            r = v;
        else if (neg[VAL_BITS-1])
            r = {1'b0, {(VAL_BITS-1){1'b1}}};
        else
            r = neg;
        return r;
    endfunction

    // Count modulo 255: fold the top bits onto the low byte, then one correction.
    function automatic logic [COLOUR_BITS-1:0] mod255(input logic [CNT_BITS-1:0] n);
        logic [COLOUR_BITS:0] s;
        s = {1'b0, n[COLOUR_BITS-1:0]} + (COLOUR_BITS + 1)'(n[CNT_BITS-1:COLOUR_BITS]);
        if (s >= (COLOUR_BITS + 1)'(255))
            s = s - (COLOUR_BITS + 1)'(255);
        return s[COLOUR_BITS-1:0];
    endfunction

endpackage

[src/bship_map.sv]
// ============================================================================
// Pixel to point mapping
// Three-stage stallable pipeline: centre offset, step multiply, offset add
// with saturation. Holds its contents while the iteration ring is full.
// ============================================================================
module bship_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bship_pkg::COORD_BITS-1:0]   pixel_x,
    input  logic [bship_pkg::COORD_BITS-1:0]   pixel_y,
    input  bship_pkg::geo_t                    geo,
    input  logic                               slot_free,
    output logic                               pt_valid,
    output bship_pkg::point_t                  pt
);
    import bship_pkg::*;

    logic                         s1_valid_reg, s1_valid_next;
    logic                         s2_valid_reg, s2_valid_next;
    logic                         s3_valid_reg, s3_valid_next;
    logic signed [DIFF_BITS-1:0]  s1_dx_reg, s1_dx_next;
    logic signed [DIFF_BITS-1:0]  s1_dy_reg, s1_dy_next;
    logic signed [PROD_BITS-1:0]  s2_px_reg, s2_px_next;
    logic signed [PROD_BITS-1:0]  s2_py_reg, s2_py_next;
    point_t                       s3_pt_reg, s3_pt_next;
    logic                         s1_ready, s2_ready, s3_ready;
    logic signed [MAP_BITS-1:0]   sum_x, sum_y;

    // A stage takes new contents when it is empty or its contents move on.
    assign s3_ready = !s3_valid_reg || slot_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign busy     = !s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? start : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

        s1_dx_next = s1_dx_reg;
        s1_dy_next = s1_dy_reg;
        if (s1_ready)
        begin
            s1_dx_next = DIFF_BITS'(pixel_x) - DIFF_BITS'(geo.width[SIZE_BITS-1:1]);
            s1_dy_next = DIFF_BITS'(pixel_y) - DIFF_BITS'(geo.height[SIZE_BITS-1:1]);
        end

        s2_px_next = s2_px_reg;
        s2_py_next = s2_py_reg;
        if (s2_ready)
        begin
            s2_px_next = PROD_BITS'(s1_dx_reg) * PROD_BITS'($signed({1'b0, geo.step_x}));
            s2_py_next = PROD_BITS'(s1_dy_reg) * PROD_BITS'($signed({1'b0, geo.step_y}));
        end

        sum_x = MAP_BITS'(s2_px_reg) + MAP_BITS'($signed(geo.off_x));
        sum_y = MAP_BITS'(s2_py_reg) + MAP_BITS'($signed(geo.off_y));
        s3_pt_next = s3_pt_reg;
        if (s3_ready)
        begin
            s3_pt_next.cr = sat_map(sum_x);
            s3_pt_next.ci = sat_map(sum_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg <= s1_dx_next;
        s1_dy_reg <= s1_dy_next;
        s2_px_reg <= s2_px_next;
        s2_py_reg <= s2_py_next;
        s3_pt_reg <= s3_pt_next;
    end

    assign pt_valid = s3_valid_reg;
    assign pt       = s3_pt_reg;

endmodule

[src/bship_iter.sv]
// ============================================================================
// Burning Ship iteration ring
// Four register stages that points circulate through, one iteration per lap.
// Finished points wait in the ring until all older points have left.
// ============================================================================
module bship_iter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bship_pkg::CNT_BITS-1:0]   limit,
    input  logic                             pt_valid,
    input  bship_pkg::point_t                pt,
    output logic                             slot_free,
    output bship_pkg::result_t               res
);
    import bship_pkg::*;

    // Ring stage registers.
    meta_t                       meta1_reg, meta1_next;
    meta_t                       meta2_reg, meta2_next;
    meta_t                       meta3_reg, meta3_next;
    meta_t                       meta4_reg, meta4_next;
    logic [MAG_BITS-1:0]         ax1_reg, ax1_next, ay1_reg, ay1_next;
    logic                        big1_reg, big1_next, lim1_reg, lim1_next;
    logic                        neg1_reg, neg1_next;
    logic [SQ_BITS-1:0]          xx2_reg, xx2_next, yy2_reg, yy2_next, xy2_reg, xy2_next;
    logic                        big2_reg, big2_next, lim2_reg, lim2_next;
    logic                        neg2_reg, neg2_next;
    logic                        esc3_reg, esc3_next, lim3_reg, lim3_next;
    logic signed [WIDE_BITS-1:0] nx3_reg, nx3_next, ny3_reg, ny3_next;
    logic signed [VAL_BITS-1:0]  x4_reg, x4_next, y4_reg, y4_next;
    logic [TAG_BITS-1:0]         itag_reg, itag_next, rtag_reg, rtag_next;

    logic                        retire, keep, take;
    meta_t                       in_meta;
    logic signed [VAL_BITS-1:0]  in_x, in_y;
    logic [VAL_BITS-1:0]         mag_x, mag_y;
    logic [2*MAG_BITS-1:0]       pxx, pyy, pxy;
    logic [SQ_BITS:0]            sq;
    logic signed [WIDE_BITS-1:0] xy_w;

    // The oldest point leaves once it is finished; otherwise it goes round again.
    assign retire    = meta4_reg.valid && meta4_reg.done && (meta4_reg.tag == rtag_reg);
    assign keep      = meta4_reg.valid && !retire;
    assign slot_free = !keep;
    assign take      = pt_valid && slot_free;

    always_comb
    begin
        // Ring entry: recirculated point, or a new one starting at z = c.
        if (keep)
        begin
            in_meta = meta4_reg;
            in_x    = x4_reg;
            in_y    = y4_reg;
        end
        else
        begin
            in_meta.valid   = take;
            in_meta.done    = 1'b0;
            in_meta.bounded = 1'b0;
            in_meta.tag     = itag_reg;
            in_meta.n       = '0;
            in_meta.cr      = pt.cr;
            in_meta.ci      = pt.ci;
            in_x            = pt.cr;
            in_y            = pt.ci;
        end
        itag_next = itag_reg + TAG_BITS'(take);
        rtag_next = rtag_reg + TAG_BITS'(retire);

        // Stage 1: magnitudes, range check against 2, limit check, product sign.
        mag_x      = in_x[VAL_BITS-1] ? VAL_BITS'(-in_x) : in_x;
        mag_y      = in_y[VAL_BITS-1] ? VAL_BITS'(-in_y) : in_y;
        meta1_next = in_meta;
        ax1_next   = mag_x[MAG_BITS-1:0];
        ay1_next   = mag_y[MAG_BITS-1:0];
        big1_next  = (|mag_x[VAL_BITS-1:MAG_BITS]) || (|mag_y[VAL_BITS-1:MAG_BITS]);
        lim1_next  = (in_meta.n >= limit);
        neg1_next  = in_x[VAL_BITS-1] ^ in_y[VAL_BITS-1];

        // Stage 2: the two truncated squares and the truncated cross product.
        pxx        = (2*MAG_BITS)'(ax1_reg) * (2*MAG_BITS)'(ax1_reg);
        pyy        = (2*MAG_BITS)'(ay1_reg) * (2*MAG_BITS)'(ay1_reg);
        pxy        = (2*MAG_BITS)'(ax1_reg) * (2*MAG_BITS)'(ay1_reg);
        meta2_next = meta1_reg;
        xx2_next   = pxx[2*MAG_BITS-1:FRAC_BITS];
        yy2_next   = pyy[2*MAG_BITS-1:FRAC_BITS];
        xy2_next   = pxy[2*MAG_BITS-1:FRAC_BITS];
        big2_next  = big1_reg;
        lim2_next  = lim1_reg;
        neg2_next  = neg1_reg;

        // Stage 3: escape test and the unsaturated new coordinates.
        sq         = {1'b0, xx2_reg} + {1'b0, yy2_reg};
        meta3_next = meta2_reg;
        esc3_next  = big2_reg || sq[SQ_BITS];
        lim3_next  = lim2_reg;
        nx3_next   = $signed(WIDE_BITS'(xx2_reg)) - $signed(WIDE_BITS'(yy2_reg))
                     + WIDE_BITS'($signed(meta2_reg.cr));
        xy_w       = $signed(WIDE_BITS'({xy2_reg, 1'b0}));
        if (neg2_reg)
            xy_w = -xy_w;
        ny3_next   = xy_w + WIDE_BITS'($signed(meta2_reg.ci));

        // Stage 4: saturate, fold and decide whether the point is finished.
        meta4_next = meta3_reg;
        x4_next    = abs_sat(sat_wide(nx3_reg));
        y4_next    = abs_sat(sat_wide(ny3_reg));
        if (meta3_reg.valid && !meta3_reg.done)
        begin
            priority if (lim3_reg)
            begin
                meta4_next.done    = 1'b1;
                meta4_next.bounded = 1'b1;
            end
            else if (esc3_reg)
            begin
                meta4_next.done = 1'b1;
            end
            else
            begin
                meta4_next.n = meta3_reg.n + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
            meta4_reg <= '0;
            itag_reg  <= '0;
            rtag_reg  <= '0;
        end
        else
        begin
            meta1_reg <= meta1_next;
            meta2_reg <= meta2_next;
            meta3_reg <= meta3_next;
            meta4_reg <= meta4_next;
            itag_reg  <= itag_next;
            rtag_reg  <= rtag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax1_reg  <= ax1_next;
        ay1_reg  <= ay1_next;
        big1_reg <= big1_next;
        lim1_reg <= lim1_next;
        neg1_reg <= neg1_next;
        xx2_reg  <= xx2_next;
        yy2_reg  <= yy2_next;
        xy2_reg  <= xy2_next;
        big2_reg <= big2_next;
        lim2_reg <= lim2_next;
        neg2_reg <= neg2_next;
        esc3_reg <= esc3_next;
        lim3_reg <= lim3_next;
        nx3_reg  <= nx3_next;
        ny3_reg  <= ny3_next;
        x4_reg   <= x4_next;
        y4_reg   <= y4_next;
    end

    assign res.valid   = retire;
    assign res.count   = meta4_reg.n;
    assign res.bounded = meta4_reg.bounded;

endmodule

[src/burning_ship_escape_time_top.sv]
// ============================================================================
// Burning Ship escape-time evaluator
// Capacity: up to four pixels in flight in the four-stage iteration ring;
// each iteration takes one lap of the ring, and a new pixel enters only when
// no recirculating point needs the entry slot.
// Reset: configuration takes its default values and the pipeline empties.
// ============================================================================
module burning_ship_escape_time_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Pixel command channel.
    input  logic                                start,
    output logic                                busy,
    input  logic [bship_pkg::COORD_BITS-1:0]    pixel_x,
    input  logic [bship_pkg::COORD_BITS-1:0]    pixel_y,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bship_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bship_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // Result channel, one cycle strobe.
    output logic                                result_valid,
    output logic [bship_pkg::CNT_BITS-1:0]      iteration_count,
    output logic                                bounded,
    output logic [bship_pkg::COLOUR_BITS-1:0]   hue,
    output logic [bship_pkg::COLOUR_BITS-1:0]   saturation,
    output logic [bship_pkg::COLOUR_BITS-1:0]   brightness
);
    import bship_pkg::*;

    // Default view: centre at (-0.5, -0.3) on an 800 by 640 frame.
    localparam logic [SIZE_BITS-1:0]        RST_WIDTH  = SIZE_BITS'(800);
    localparam logic [SIZE_BITS-1:0]        RST_HEIGHT = SIZE_BITS'(640);
    localparam logic signed [OFS_BITS-1:0]  RST_OFF_X  = -32'sd134217728;
    localparam logic signed [OFS_BITS-1:0]  RST_OFF_Y  = -32'sd80530637;
    localparam logic [STEP_BITS-1:0]        RST_STEP_X = STEP_BITS'(1006633);
    localparam logic [STEP_BITS-1:0]        RST_STEP_Y = STEP_BITS'(838861);
    localparam logic [CNT_BITS-1:0]         RST_LIMIT  = CNT_BITS'(300);

    geo_t                     geo_reg, geo_next;
    logic [CNT_BITS-1:0]      limit_reg, limit_next;
    logic                     pt_valid;
    point_t                   pt;
    logic                     slot_free;
    result_t                  res;

    logic                     valid_reg, valid_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic                     bounded_reg, bounded_next;
    logic [COLOUR_BITS-1:0]   hue_reg, hue_next;
    logic [COLOUR_BITS-1:0]   sat_reg, sat_next;
    logic [COLOUR_BITS-1:0]   bright_reg, bright_next;
    logic [COLOUR_BITS-1:0]   count_mod;

    // Configuration writes are always taken. Software must write only while
    // the block is idle; this is not enforced. Pipelines read them directly.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        geo_next   = geo_reg;
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  geo_next.width  = cfg_data[SIZE_BITS-1:0];
                CFG_HEIGHT: geo_next.height = cfg_data[SIZE_BITS-1:0];
                CFG_OFF_X:  geo_next.off_x  = $signed(cfg_data[OFS_BITS-1:0]);
                CFG_OFF_Y:  geo_next.off_y  = $signed(cfg_data[OFS_BITS-1:0]);
                CFG_STEP_X: geo_next.step_x = cfg_data[STEP_BITS-1:0];
                CFG_STEP_Y: geo_next.step_y = cfg_data[STEP_BITS-1:0];
                CFG_LIMIT:  limit_next      = cfg_data[CNT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_reg.width  <= RST_WIDTH;
            geo_reg.height <= RST_HEIGHT;
            geo_reg.off_x  <= RST_OFF_X;
            geo_reg.off_y  <= RST_OFF_Y;
            geo_reg.step_x <= RST_STEP_X;
            geo_reg.step_y <= RST_STEP_Y;
            limit_reg      <= RST_LIMIT;
        end
        else
        begin
            geo_reg   <= geo_next;
            limit_reg <= limit_next;
        end
    end

    // The mapping pipeline turns a pixel into the complex point c. It stalls,
    // and raises busy, only when the iteration ring has no free slot.
    bship_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .geo       (geo_reg),
        .slot_free (slot_free),
        .pt_valid  (pt_valid),
        .pt        (pt)
    );

    // The ring never stalls; each point leaves in the order it entered.
    bship_iter u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .pt_valid  (pt_valid),
        .pt        (pt),
        .slot_free (slot_free),
        .res       (res)
    );

    // Result register: colour components are derived from the count as the
    // transaction leaves the ring. The strobe lasts exactly one cycle, since
    // at most one point retires per cycle.
    assign count_mod = mod255(res.count);

    always_comb
    begin
        valid_next   = res.valid;
        count_next   = count_reg;
        bounded_next = bounded_reg;
        hue_next     = hue_reg;
        sat_next     = sat_reg;
        bright_next  = bright_reg;
        if (res.valid)
        begin
            count_next   = res.count;
            bounded_next = res.bounded;
            hue_next     = res.count[COLOUR_BITS-1:0];
            sat_next     = count_mod;
            bright_next  = res.bounded ? '0 : count_mod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        bounded_reg <= bounded_next;
        hue_reg     <= hue_next;
        sat_reg     <= sat_next;
        bright_reg  <= bright_next;
    end

    assign result_valid    = valid_reg;
    assign iteration_count = count_reg;
    assign bounded         = bounded_reg;
    assign hue             = hue_reg;
    assign saturation      = sat_reg;
    assign brightness      = bright_reg;

endmodule

[bench/tb_burning_ship_escape_time_top.sv]
// ============================================================================
// Burning Ship escape-time evaluator testbench
// Drives pixel commands into the evaluator under several view settings and
// checks every result strobe against an in-bench fixed-point predictor of the
// escape-time iteration, field by field and in order of acceptance.
// ============================================================================
module tb_burning_ship_escape_time_top;

    import bship_pkg::*;

    // Value range of the signed fixed-point format, and the escape bounds.
    localparam longint          VAL_MAX = (longint'(1) << (FRAC_BITS + 3)) - 1;
    localparam longint          VAL_MIN = -VAL_MAX - 1;
    localparam longint unsigned TWO_Q   = 64'd1 << (FRAC_BITS + 1);
    localparam longint unsigned FOUR_Q  = 64'd1 << (FRAC_BITS + 2);

    // Register index that decodes to nothing; a write to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    // Reset-time view, used again when the default view is reprogrammed.
    localparam int     DEF_WIDTH  = 800;
    localparam int     DEF_HEIGHT = 640;
    localparam int     DEF_OFF_X  = -134217728;
    localparam int     DEF_OFF_Y  = -80530637;
    localparam int     DEF_STEP_X = 1006633;
    localparam int     DEF_STEP_Y = 838861;
    localparam int     DEF_LIMIT  = 300;

    localparam int     RESET_CYCLES  = 7;
    localparam int     DRAIN_CYCLES  = 50000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 64;
    localparam longint TIMEOUT_UNITS = 64'd40_000_000;

    // One colour result as the block reports it.
    typedef struct packed {
        logic [CNT_BITS-1:0]    count;
        logic                   bounded;
        logic [COLOUR_BITS-1:0] hue;
        logic [COLOUR_BITS-1:0] sat;
        logic [COLOUR_BITS-1:0] bri;
    } colour_t;

    // Holds a private copy of the view registers, predicts the colour of each
    // accepted pixel and compares the strobed results in arrival order.
    class pixel_colour_checker;
        longint  width_q;
        longint  height_q;
        longint  off_x;
        longint  off_y;
        longint  step_x;
        longint  step_y;
        longint  limit;
        colour_t awaited[$];
        int      errors;

        function new();
            width_q  = longint'(DEF_WIDTH);
            height_q = longint'(DEF_HEIGHT);
            off_x    = longint'(DEF_OFF_X);
            off_y    = longint'(DEF_OFF_Y);
            step_x   = longint'(DEF_STEP_X);
            step_y   = longint'(DEF_STEP_Y);
            limit    = longint'(DEF_LIMIT);
            errors   = 0;
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_WIDTH:  width_q  = longint'(data[SIZE_BITS-1:0]);
                CFG_HEIGHT: height_q = longint'(data[SIZE_BITS-1:0]);
                CFG_OFF_X:  off_x    = longint'($signed(data[OFS_BITS-1:0]));
                CFG_OFF_Y:  off_y    = longint'($signed(data[OFS_BITS-1:0]));
                CFG_STEP_X: step_x   = longint'(data[STEP_BITS-1:0]);
                CFG_STEP_Y: step_y   = longint'(data[STEP_BITS-1:0]);
                CFG_LIMIT:  limit    = longint'(data[CNT_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > VAL_MAX)
                return VAL_MAX;
            if (v < VAL_MIN)
                return VAL_MIN;
            return v;
        endfunction

        // Absolute value; the most negative value folds to the most positive.
        function longint fold(longint v);
            if (v < 0)
                return (v <= -VAL_MAX) ? VAL_MAX : -v;
            return v;
        endfunction

        function longint map_axis(logic [COORD_BITS-1:0] pix, longint size,
                                  longint step, longint off);
            longint d;
            d = longint'(pix) - size / 2;
            return clamp(d * step + off);
        endfunction

        function colour_t escape_time(logic [COORD_BITS-1:0] px,
                                      logic [COORD_BITS-1:0] py);
            longint          cr;
            longint          ci;
            longint          x;
            longint          y;
            longint          pxy;
            longint          n;
            longint unsigned ax;
            longint unsigned ay;
            longint unsigned xx;
            longint unsigned yy;
            longint unsigned xy;
            colour_t         r;
            cr = map_axis(px, width_q, step_x, off_x);
            ci = map_axis(py, height_q, step_y, off_y);
            x  = cr;
            y  = ci;
            n  = 0;
            while (n < limit)
            begin
                ax = (x < 0) ? -x : x;
                ay = (y < 0) ? -y : y;
                if (ax >= TWO_Q || ay >= TWO_Q)
                    break;
                // Products on magnitudes, truncated toward zero.
                xx = (ax * ax) >> FRAC_BITS;
                yy = (ay * ay) >> FRAC_BITS;
                if (xx + yy >= FOUR_Q)
                    break;
                xy  = ((ax * ay) >> FRAC_BITS) << 1;
                pxy = ((x < 0) != (y < 0)) ? -longint'(xy) : longint'(xy);
                x   = fold(clamp(longint'(xx) - longint'(yy) + cr));
                y   = fold(clamp(pxy + ci));
                n++;
            end
            r.count   = CNT_BITS'(n);
            r.bounded = (n == limit);
            r.hue     = COLOUR_BITS'(n % 256);
            r.sat     = COLOUR_BITS'(n % 255);
            r.bri     = r.bounded ? '0 : COLOUR_BITS'(n % 255);
            return r;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
            awaited.push_back(escape_time(px, py));
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void check_colour(colour_t got);
            colour_t want;
            if (awaited.size() == 0)
            begin
                $error("result strobe with no pixel transaction outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.count !== want.count)
            begin
                $error("iteration_count mismatch: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.bounded !== want.bounded)
            begin
                $error("bounded mismatch: expected %0d, got %0d", want.bounded, got.bounded);
                errors++;
            end
            if (got.hue !== want.hue)
            begin
                $error("hue mismatch: expected %0d, got %0d", want.hue, got.hue);
                errors++;
            end
            if (got.sat !== want.sat)
            begin
                $error("saturation mismatch: expected %0d, got %0d", want.sat, got.sat);
                errors++;
            end
            if (got.bri !== want.bri)
            begin
                $error("brightness mismatch: expected %0d, got %0d", want.bri, got.bri);
                errors++;
            end
        endfunction

        // Results that never arrived count as failures and are dropped, so
        // that later phases are not compared against stale predictions.
        function void abandon();
            $error("%0d pixel results never arrived", awaited.size());
            errors += awaited.size();
            awaited.delete();
        endfunction
    endclass

    // Every input is known from time zero; reset is held low from the start.
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [COORD_BITS-1:0]    pixel_x = '0;
    logic [COORD_BITS-1:0]    pixel_y = '0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     result_valid;
    logic [CNT_BITS-1:0]      iteration_count;
    logic                     bounded;
    logic [COLOUR_BITS-1:0]   hue;
    logic [COLOUR_BITS-1:0]   saturation;
    logic [COLOUR_BITS-1:0]   brightness;

    pixel_colour_checker sb;
    int                  burst_left = 0;

    burning_ship_escape_time_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .iteration_count (iteration_count),
        .bounded         (bounded),
        .hue             (hue),
        .saturation      (saturation),
        .brightness      (brightness)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Results are taken at the edge that ends their strobe cycle. Reading
    // straight after the edge sees the values from before it, since the
    // block's own updates for that edge have not been applied yet.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_colour({iteration_count, bounded, hue, saturation, brightness});
    end

    // Sender gaps: mostly none or short, a few long, and now and then a burst
    // of back-to-back transactions so that the ring fills completely.
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Fills the bits above a register's width with noise; they must be masked.
    function automatic logic [31:0] junk_above(logic [31:0] v, int bits);
        logic [31:0] mask;
        mask = (32'd1 << bits) - 32'd1;
        return ($urandom & ~mask) | (v & mask);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 0;
            1:       return 4095;
            2:       return 2048;
            3:       return 1;
            default: return $urandom_range(8, 2048);
        endcase
    endfunction

    // Most pixels fall inside the programmed frame; the rest anywhere.
    function automatic logic [COORD_BITS-1:0] pick_coord(int size);
        int span;
        span = (size > 2048) ? 2048 : size;
        if (span > 0 && $urandom_range(0, 99) < 85)
            return COORD_BITS'($urandom_range(0, span - 1));
        return COORD_BITS'($urandom_range(0, 2047));
    endfunction

    // One pixel transaction: start stays high until an edge sees busy low.
    // A zero gap leaves start high, so the next pixel follows at once.
    task automatic feed_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
        int gap;
        start   <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        do @(posedge clk); while (busy);
        sb.note_pixel(px, py);
        gap = next_gap();
        if (gap > 0)
        begin
            start   <= 1'b0;
            pixel_x <= COORD_BITS'($urandom);
            pixel_y <= COORD_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding pixel has reported.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_CYCLES)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending() != 0)
            sb.abandon();
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, data);
    endtask

    // Reprograms the whole view once the block has gone idle. Valid stays high
    // across the writes and is lowered only after the last transaction.
    task automatic program_view(int w, int h, logic [31:0] ox, logic [31:0] oy,
                                logic [31:0] sx, logic [31:0] sy, int lim);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_WIDTH,  junk_above(w, SIZE_BITS));
        write_reg(CFG_HEIGHT, junk_above(h, SIZE_BITS));
        write_reg(CFG_OFF_X,  ox);
        write_reg(CFG_OFF_Y,  oy);
        write_reg(CFG_STEP_X, junk_above(sx, STEP_BITS));
        write_reg(CFG_STEP_Y, junk_above(sy, STEP_BITS));
        write_reg(CFG_LIMIT,  junk_above(lim, CNT_BITS));
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Random pixels over a view; halfway through, the sender waits for the
    // block to empty completely before carrying on.
    task automatic random_pixels(int items, int w, int h);
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                wait_for_results();
            feed_pixel(pick_coord(w), pick_coord(h));
        end
    endtask

    // A random view roughly framing the ship: three units wide at zoom zero,
    // narrowed by a random power of two, centred somewhere near the set.
    task automatic random_view(int lim, int items);
        int          w;
        int          h;
        int          zoom;
        longint      sx;
        longint      sy;
        logic [31:0] ox;
        logic [31:0] oy;
        w    = pick_size();
        h    = pick_size();
        zoom = $urandom_range(0, 10);
        sx   = ((longint'(3) << FRAC_BITS) / longint'((w > 0) ? w : 1)) >> zoom;
        sy   = ((longint'(2) << FRAC_BITS) / longint'((h > 0) ? h : 1)) >> zoom;
        if ($urandom_range(0, 7) == 0)
        begin
            ox = $urandom;
            oy = $urandom;
        end
        else
        begin
            ox = int'($urandom_range(0, 7 << (FRAC_BITS - 1))) - (1 << (FRAC_BITS + 1));
            oy = int'($urandom_range(0, 3 << FRAC_BITS)) - (1 << (FRAC_BITS + 1));
        end
        program_view(w, h, ox, oy, 32'(sx), 32'(sy), lim);
        random_pixels(items, w, h);
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset view: extreme coordinates, alternating bit patterns, the centre
        // of the frame and the pixels at and beside its far edge.
        feed_pixel(11'd0, 11'd0);
        feed_pixel(11'd2047, 11'd2047);
        feed_pixel(11'd0, 11'd2047);
        feed_pixel(11'd2047, 11'd0);
        feed_pixel(11'h555, 11'h2AA);
        feed_pixel(11'h2AA, 11'h555);
        feed_pixel(11'd400, 11'd320);
        feed_pixel(11'd399, 11'd321);
        feed_pixel(11'd800, 11'd640);
        feed_pixel(11'd799, 11'd639);

        // Square view of plus and minus two at the largest limit: the origin
        // never escapes, minus two on either axis escapes before the first
        // iteration, and one and a half on both axes escapes on the sum of
        // squares while each part is still below two.
        program_view(2048, 2048, 32'd0, 32'd0, 32'd1 << 19, 32'd1 << 19, 1023);
        feed_pixel(11'd1024, 11'd1024);
        feed_pixel(11'd0, 11'd1024);
        feed_pixel(11'd1024, 11'd0);
        feed_pixel(11'd1792, 11'd1792);
        feed_pixel(11'd768, 11'd768);
        feed_pixel(11'd2047, 11'd2047);

        // Extreme registers: the mapping saturates at both ends of the range,
        // and a zero limit gives a bounded pixel with no iteration at all.
        program_view(4095, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        feed_pixel(11'd0, 11'd0);
        feed_pixel(11'd2047, 11'd2047);
        feed_pixel(11'd2047, 11'd0);
        feed_pixel(11'd0, 11'd2047);

        // Limit of one: points that would escape on the next test still count
        // as bounded once the single iteration has been done.
        program_view(2048, 2048, 32'd0, 32'd0, 32'd1 << 19, 32'd0, 1);
        feed_pixel(11'd1024, 11'd5);
        feed_pixel(11'd1997, 11'd0);
        feed_pixel(11'd2047, 11'd0);
        feed_pixel(11'd0, 11'd0);

        // Random part: the default view, limits on the colour wrap points,
        // and a spread of small and large limits.
        program_view(DEF_WIDTH, DEF_HEIGHT, DEF_OFF_X, DEF_OFF_Y,
                     DEF_STEP_X, DEF_STEP_Y, DEF_LIMIT);
        random_pixels(150, DEF_WIDTH, DEF_HEIGHT);
        random_view(255, 100);
        random_view(510, 60);
        random_view($urandom_range(2, 100), 100);
        random_view($urandom_range(1, 1023), 40);
        random_view($urandom_range(2, 40), 170);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("burning_ship_escape_time_top verification clean");
        else
            $display("burning_ship_escape_time_top verification failed");
        $finish;
    end

    // Hard stop should the block hang on either handshake.
    initial
    begin
        #TIMEOUT_UNITS;
        $display("burning_ship_escape_time_top verification failed");
        $finish;
    end

endmodule
